@@ sv/iod_pkg.sv @@
// Package for the instruction opcode decoder: major opcode table and
// group base ids. No dependencies.
`timescale 1ns / 1ps
package iod_pkg;

    localparam logic [7:0] NO_ID = 8'hFF;

    localparam logic [7:0] ID_RSUBK = 8'd5;
    localparam logic [7:0] ID_MUL   = 8'd16;
    localparam logic [7:0] ID_BSRL  = 8'd17;
    localparam logic [7:0] ID_IDIV  = 8'd18;
    localparam logic [7:0] ID_GETD  = 8'd19;
    localparam logic [7:0] ID_FADD  = 8'd20;
    localparam logic [7:0] ID_BSRLI = 8'd22;
    localparam logic [7:0] ID_GET   = 8'd23;
    localparam logic [7:0] ID_OR    = 8'd24;
    localparam logic [7:0] ID_XOR   = 8'd26;
    localparam logic [7:0] ID_ANDN  = 8'd27;
    localparam logic [7:0] ID_SEXT8 = 8'd28;
    localparam logic [7:0] ID_MFS   = 8'd29;
    localparam logic [7:0] ID_BR    = 8'd30;
    localparam logic [7:0] ID_BEQ   = 8'd31;
    localparam logic [7:0] ID_RTSD  = 8'd37;
    localparam logic [7:0] ID_BRI   = 8'd38;
    localparam logic [7:0] ID_BEQI  = 8'd39;
    localparam logic [7:0] ID_LBU   = 8'd40;
    localparam logic [7:0] ID_LHU   = 8'd41;
    localparam logic [7:0] ID_LW    = 8'd42;
    localparam logic [7:0] ID_SB    = 8'd43;
    localparam logic [7:0] ID_SH    = 8'd44;
    localparam logic [7:0] ID_SW    = 8'd45;

    // Major opcode table; NO_ID marks an unused opcode.
    function automatic logic [7:0] major_base(input logic [5:0] op);
        logic [7:0] r;
        case (op)
            6'd20, 6'd21, 6'd23, 6'd26, 6'd28, 6'd29, 6'd30, 6'd31,
            6'd51, 6'd55, 6'd59, 6'd63: r = NO_ID;
            6'd22: r = 8'd20;
            6'd24: r = 8'd21;
            6'd25: r = 8'd22;
            6'd27: r = 8'd23;
            6'd52: r = 8'd43;
            6'd53: r = 8'd44;
            6'd54: r = 8'd45;
            6'd56: r = 8'd46;
            6'd57: r = 8'd47;
            6'd58: r = 8'd48;
            6'd60: r = 8'd49;
            6'd61: r = 8'd50;
            6'd62: r = 8'd51;
            default:
            begin
                if (op < 6'd20)
                begin
                    r = {2'b00, op};
                end
                else
                begin
                    r = {2'b00, op} - 8'd8;
                end
            end
        endcase
        return r;
    endfunction

endpackage

@@ sv/instruction_opcode_decoder.sv @@
// Top level of the instruction opcode decoder: one registered decode pass.
// Depends on iod_pkg for the opcode table and group ids.
//
// Usage: drive word and pulse start while busy is low; busy is always low,
// so a word may be started every cycle. In the cycle after a word is taken,
// done is high for exactly one cycle with the decoded result: valid_res,
// instr_id (0 when invalid) and the raw operand slices of the word.
// Throughput is one word per cycle, set by the single register stage after
// the decode logic. The receiver cannot stall and has to take each
// result in the cycle done is high.
// Reset clears done; result payload registers are not reset.
`timescale 1ns / 1ps
module instruction_opcode_decoder
    import iod_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        word,
    output logic               done,
    output logic               valid_res,
    output logic [7:0]         instr_id,
    output logic [4:0]         dest_reg,
    output logic [4:0]         src_a_reg,
    output logic [4:0]         src_b_reg,
    output logic signed [15:0] immediate,
    output logic [4:0]         shift_amount,
    output logic [3:0]         link_id,
    output logic [13:0]        special_reg
);

    logic        done_reg;
    logic [7:0]  id_reg;
    logic [31:0] word_reg;
    logic [7:0]  id_next;
    logic [7:0]  base;
    logic [10:0] f;
    logic [1:0]  m9;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [5:0]  s;

    assign busy = 1'b0;

    always_comb
    begin
        base = major_base(word[31:26]);
        f    = word[10:0];
        m9   = word[10:9];
        rd   = word[25:21];
        ra   = word[20:16];
        s    = 6'd0;
        id_next = base;
        case (base)
            ID_MUL:
                id_next = (f == 11'd0) ? ID_MUL
                        : (f <= 11'd3) ? 8'd51 + {5'd0, f[2:0]} : NO_ID;
            ID_SEXT8:
            begin
                case (f)
                    11'h060: id_next = ID_SEXT8;
                    11'h068: id_next = 8'd55;
                    11'h064: id_next = 8'd56;
                    11'h066: id_next = 8'd57;
                    11'h074: id_next = 8'd58;
                    11'h061: id_next = 8'd59;
                    11'h041: id_next = 8'd60;
                    11'h021: id_next = 8'd61;
                    11'h001: id_next = 8'd62;
                    default: id_next = NO_ID;
                endcase
            end
            ID_BEQ, ID_BEQI:
            begin
                // Condition codes 0x01..0x05 and 0x10..0x15 map to consecutive ids 1..11 above the base, in pairs.
                if (rd == 5'd0)
                begin
                    id_next = base;
                end
                else if (rd[3:0] >= 4'd1 && rd[3:0] <= 4'd5 && !(rd[3:0] == 4'd0))
                begin
                    id_next = NO_ID;
                end
                else
                begin
                    id_next = NO_ID;
                end
                if (rd != 5'd0 && rd[3] == 1'b0 && rd[2:0] <= 3'd5
                    && (rd[2:0] != 3'd0 || rd[4]))
                begin
                    // idx = 1 for 0x10, else 2*(6-low)+high, computed below
                    id_next = ((base == ID_BEQ) ? 8'd62 : 8'd73)
                            + ((rd[2:0] == 3'd0) ? 8'd1
                               : {4'd0, (3'd5 - rd[2:0]), 1'b0} + 8'd2 + {7'd0, rd[4]});
                end
            end
            ID_BR, ID_BRI:
            begin
                if (ra == 5'd0)
                begin
                    id_next = base;
                end
                else if (ra[1:0] == 2'b00 && ra[4:2] >= 3'd2)
                begin
                    id_next = ((base == ID_BR) ? 8'd85 : 8'd91) + {5'd0, ra[4:2]} - 8'd2;
                end
                else
                begin
                    id_next = NO_ID;
                end
            end
            ID_BSRL, ID_BSRLI:
            begin
                case (m9)
                    2'd0:    id_next = base;
                    2'd2:    id_next = (base == ID_BSRL) ? 8'd97 : 8'd99;
                    2'd1:    id_next = (base == ID_BSRL) ? 8'd98 : 8'd100;
                    default: id_next = NO_ID;
                endcase
            end
            ID_RSUBK:
                id_next = (f == 11'd0) ? ID_RSUBK : (f == 11'd1) ? 8'd101
                        : (f == 11'd3) ? 8'd102 : NO_ID;
            ID_FADD:
            begin
                case (f)
                    11'h000: id_next = ID_FADD;
                    11'h080: id_next = 8'd103;
                    11'h100: id_next = 8'd104;
                    11'h180: id_next = 8'd105;
                    11'h200: id_next = 8'd106;
                    11'h210: id_next = 8'd107;
                    11'h220: id_next = 8'd108;
                    11'h230: id_next = 8'd109;
                    11'h240: id_next = 8'd110;
                    11'h250: id_next = 8'd111;
                    11'h260: id_next = 8'd112;
                    11'h280: id_next = 8'd113;
                    11'h300: id_next = 8'd114;
                    11'h380: id_next = 8'd115;
                    default: id_next = NO_ID;
                endcase
            end
            ID_GET, ID_GETD:
            begin
                s = (base == ID_GET) ? word[15:10] : word[10:5];
                if (s == 6'd0)
                begin
                    id_next = base;
                end
                else if (!s[5])
                begin
                    id_next = ((base == ID_GET) ? 8'd115 : 8'd162) + {2'd0, s};
                end
                else if (!s[0])
                begin
                    id_next = ((base == ID_GET) ? 8'd147 : 8'd194) + {4'd0, s[4:1]};
                end
                else
                begin
                    id_next = NO_ID;
                end
            end
            ID_IDIV:
                id_next = (word[1:0] == 2'd0) ? ID_IDIV
                        : (word[1:0] == 2'd2) ? 8'd210 : NO_ID;
            ID_LBU:  id_next = m9[0] ? 8'd211 : ID_LBU;
            ID_LHU:  id_next = m9[0] ? 8'd212 : ID_LHU;
            ID_LW:
                id_next = (m9 == 2'd0) ? ID_LW : (m9 == 2'd1) ? 8'd213
                        : (m9 == 2'd2) ? 8'd214 : NO_ID;
            ID_SB:   id_next = m9[0] ? 8'd215 : ID_SB;
            ID_SH:   id_next = m9[0] ? 8'd216 : ID_SH;
            ID_SW:
                id_next = (m9 == 2'd0) ? ID_SW : (m9 == 2'd1) ? 8'd217
                        : (m9 == 2'd2) ? 8'd218 : NO_ID;
            ID_MFS:
            begin
                if (!word[15])
                begin
                    id_next = word[16] ? 8'd220 : 8'd219;
                end
                else
                begin
                    id_next = word[14] ? 8'd221 : ID_MFS;
                end
            end
            ID_OR:
                id_next = (f == 11'd0) ? ID_OR : (f == 11'h400) ? 8'd222 : NO_ID;
            ID_XOR:
                id_next = (f == 11'd0) ? ID_XOR : (f == 11'h400) ? 8'd223 : NO_ID;
            ID_ANDN:
                id_next = (f == 11'd0) ? ID_ANDN : (f == 11'h400) ? 8'd224 : NO_ID;
            ID_RTSD:
            begin
                case (rd)
                    5'h10:   id_next = ID_RTSD;
                    5'h11:   id_next = 8'd225;
                    5'h12:   id_next = 8'd226;
                    5'h14:   id_next = 8'd227;
                    default: id_next = NO_ID;
                endcase
            end
            default: id_next = base;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            id_reg   <= id_next;
            word_reg <= word;
        end
    end

    assign done         = done_reg;
    assign valid_res    = (id_reg != NO_ID);
    assign instr_id     = (id_reg != NO_ID) ? id_reg : 8'd0;
    assign dest_reg     = word_reg[25:21];
    assign src_a_reg    = word_reg[20:16];
    assign src_b_reg    = word_reg[15:11];
    assign immediate    = word_reg[15:0];
    assign shift_amount = word_reg[4:0];
    assign link_id      = word_reg[3:0];
    assign special_reg  = word_reg[13:0];

endmodule
